FILE: rtl/zrh_pkg.sv
// Shared types, constants and helpers for the zero-run height decoder.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package zrh_pkg;

  localparam int MAX_DIM = 64;
  localparam int DIM_W   = 7;
  localparam int CELL_W  = 12;
  localparam int RUN_W   = 13;
  localparam int LEFT_W  = 31;
  localparam int WORD_W  = 32;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;
  localparam int PH_W    = 2;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = 1;
  localparam int FIFO_CW    = 2;

  // parse phases
  localparam logic [PH_W-1:0] PH_SIG   = 2'd0;
  localparam logic [PH_W-1:0] PH_COUNT = 2'd1;
  localparam logic [PH_W-1:0] PH_SKIP  = 2'd2;
  localparam logic [PH_W-1:0] PH_LIT   = 2'd3;

  // register index, taken from paddr[2]
  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  typedef struct packed {
    logic [7:0]       height;
    logic [RUN_W-1:0] run_length;
    logic             chunk_done;
    logic             bad_signature;
  } cmd_t;

  // signature "chnk", first byte first
  function automatic logic [7:0] sig_byte(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = 8'h63;
      2'd1:    b = 8'h68;
      2'd2:    b = 8'h6E;
      default: b = 8'h6B;
    endcase
    return b;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: rtl/zrh_if.sv
// Valid/ready channel interfaces for the byte input and the run result.
// Depends on zrh_pkg for field widths.
interface zrh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface zrh_out_if;
  logic                       valid;
  logic                       ready;
  logic [7:0]                 height;
  logic [zrh_pkg::RUN_W-1:0]  run_length;
  logic [zrh_pkg::CELL_W-1:0] first_cell;
  logic                       chunk_done;
  logic                       bad_signature;

  modport source (output valid, output height, output run_length, output first_cell,
                  output chunk_done, output bad_signature, input ready);
  modport sink   (input valid, input height, input run_length, input first_cell,
                  input chunk_done, input bad_signature, output ready);
endinterface

FILE: rtl/zrh_front.sv
// Front end: takes one byte per request, checks the signature, assembles count and
// skip words, tracks cells filled and pushes run commands. Depends on zrh_pkg, zrh_if.
module zrh_front (
  input  logic                      clk,
  input  logic                      rst_n,
  zrh_in_if.sink                    in_ch,
  input  logic [zrh_pkg::DIM_W-1:0] cols,
  input  logic [zrh_pkg::DIM_W-1:0] rows,
  input  logic                      restart,
  input  logic                      q_full,
  output logic                      q_push,
  output zrh_pkg::cmd_t             q_cmd
);

  logic [zrh_pkg::PH_W-1:0]   phase_r, phase_nxt;
  logic [1:0]                 bpos_r, bpos_nxt;
  logic [23:0]                wasm_r, wasm_nxt;
  logic                       sig_ok_r, sig_ok_nxt;
  logic [zrh_pkg::CELL_W-1:0] filled_r, filled_nxt;
  logic [zrh_pkg::LEFT_W-1:0] left_r, left_nxt;

  logic                       accept;
  logic [7:0]                 b;
  logic [zrh_pkg::WORD_W-1:0] word;
  logic                       word_pos;
  logic                       emit;
  logic [7:0]                 emit_h;
  logic [zrh_pkg::LEFT_W-1:0] want;
  logic [zrh_pkg::RUN_W-1:0]  total;
  logic [zrh_pkg::RUN_W-1:0]  remain;
  logic [zrh_pkg::RUN_W-1:0]  run;
  logic                       done;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign b           = in_ch.data_byte;
  assign word        = {b, wasm_r};
  assign word_pos    = (word != '0) && !word[zrh_pkg::WORD_W-1];

  assign total  = zrh_pkg::RUN_W'(zrh_pkg::clamp_dim(cols)) *
                  zrh_pkg::RUN_W'(zrh_pkg::clamp_dim(rows));
  assign remain = total - {1'b0, filled_r};

  always_comb begin
    phase_nxt  = phase_r;
    bpos_nxt   = bpos_r;
    wasm_nxt   = wasm_r;
    sig_ok_nxt = sig_ok_r;
    filled_nxt = filled_r;
    left_nxt   = left_r;
    emit       = 1'b0;
    emit_h     = '0;
    want       = zrh_pkg::LEFT_W'(1);
    q_push     = 1'b0;
    q_cmd      = '0;
    run        = '0;
    done       = 1'b0;

    if (accept) begin
      case (phase_r)
        zrh_pkg::PH_LIT: begin
          left_nxt = left_r - zrh_pkg::LEFT_W'(1);
          if (left_nxt == '0) begin
            phase_nxt = zrh_pkg::PH_COUNT;
          end
          emit   = 1'b1;
          emit_h = b;
        end
        zrh_pkg::PH_SIG: begin
          sig_ok_nxt = sig_ok_r && (b == zrh_pkg::sig_byte(bpos_r));
          bpos_nxt   = bpos_r + 2'd1;
          if (bpos_r == 2'd3) begin
            if (sig_ok_nxt) begin
              phase_nxt = zrh_pkg::PH_COUNT;
              wasm_nxt  = '0;
            end else begin
              // report the bad signature and look for a new one
              sig_ok_nxt          = 1'b1;
              q_push              = 1'b1;
              q_cmd.bad_signature = 1'b1;
            end
          end
        end
        zrh_pkg::PH_COUNT, zrh_pkg::PH_SKIP: begin
          bpos_nxt = bpos_r + 2'd1;
          if (bpos_r != 2'd3) begin
            wasm_nxt[{bpos_r, 3'b000} +: 8] = b;
          end else begin
            wasm_nxt = '0;
            if (phase_r == zrh_pkg::PH_COUNT) begin
              if (word == '1) begin
                phase_nxt = zrh_pkg::PH_SKIP;
              end else if (word_pos) begin
                left_nxt  = word[zrh_pkg::LEFT_W-1:0];
                phase_nxt = zrh_pkg::PH_LIT;
              end else begin
                emit = 1'b1;
              end
            end else begin
              phase_nxt = zrh_pkg::PH_COUNT;
              emit      = 1'b1;
              if (word_pos) begin
                want = word[zrh_pkg::LEFT_W-1:0];
              end
            end
          end
        end
        default: begin
          phase_nxt = zrh_pkg::PH_SIG;
        end
      endcase
    end

    if (emit) begin
      // cut the run at the chunk's last cell
      if (want[zrh_pkg::LEFT_W-1:zrh_pkg::RUN_W] == '0 &&
          want[zrh_pkg::RUN_W-1:0] < remain) begin
        run = want[zrh_pkg::RUN_W-1:0];
      end else begin
        run = remain;
      end
      done                = (run == remain);
      q_push              = 1'b1;
      q_cmd.height        = emit_h;
      q_cmd.run_length    = run;
      q_cmd.chunk_done    = done;
      filled_nxt          = filled_r + run[zrh_pkg::CELL_W-1:0];
    end

    if (done || restart) begin
      phase_nxt  = zrh_pkg::PH_SIG;
      bpos_nxt   = '0;
      wasm_nxt   = '0;
      sig_ok_nxt = 1'b1;
      filled_nxt = '0;
      left_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= zrh_pkg::PH_SIG;
      bpos_r   <= '0;
      wasm_r   <= '0;
      sig_ok_r <= 1'b1;
      filled_r <= '0;
      left_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      bpos_r   <= bpos_nxt;
      wasm_r   <= wasm_nxt;
      sig_ok_r <= sig_ok_nxt;
      filled_r <= filled_nxt;
      left_r   <= left_nxt;
    end
  end

endmodule

FILE: rtl/zrh_fifo.sv
// Two-entry command queue between the parse front end and the output back end.
// Depends on zrh_pkg for the command type and depth.
module zrh_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  zrh_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output zrh_pkg::cmd_t head
);

  zrh_pkg::cmd_t               mem_r [zrh_pkg::FIFO_DEPTH];
  logic [zrh_pkg::FIFO_AW-1:0] wptr_r, wptr_nxt;
  logic [zrh_pkg::FIFO_AW-1:0] rptr_r, rptr_nxt;
  logic [zrh_pkg::FIFO_CW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == zrh_pkg::FIFO_CW'(zrh_pkg::FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + zrh_pkg::FIFO_AW'(1) : wptr_r;
    rptr_nxt = pop  ? rptr_r + zrh_pkg::FIFO_AW'(1) : rptr_r;
    cnt_nxt  = cnt_r + zrh_pkg::FIFO_CW'(push) - zrh_pkg::FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/zrh_back.sv
// Back end: pops run commands, places each run at the current cell position and holds
// the result in an output register. Depends on zrh_pkg, zrh_if.
module zrh_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          restart,
  input  logic          q_valid,
  input  zrh_pkg::cmd_t q_head,
  output logic          q_pop,
  zrh_out_if.source     out_ch
);

  logic                       valid_r, valid_nxt;
  zrh_pkg::cmd_t              cmd_r;
  logic [zrh_pkg::CELL_W-1:0] first_r;
  logic [zrh_pkg::CELL_W-1:0] pos_r, pos_nxt;
  logic                       load;

  assign load  = q_valid && (!valid_r || out_ch.ready);
  assign q_pop = load;

  always_comb begin
    valid_nxt = valid_r;
    pos_nxt   = pos_r;
    if (load) begin
      valid_nxt = 1'b1;
      // advance past this run; back to the chunk start on chunk end or bad signature
      if (q_head.chunk_done || q_head.bad_signature) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + q_head.run_length[zrh_pkg::CELL_W-1:0];
      end
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
    if (restart) begin
      pos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r   <= q_head;
      first_r <= pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pos_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      pos_r   <= pos_nxt;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.height        = cmd_r.height;
  assign out_ch.run_length    = cmd_r.run_length;
  assign out_ch.first_cell    = first_r;
  assign out_ch.chunk_done    = cmd_r.chunk_done;
  assign out_ch.bad_signature = cmd_r.bad_signature;

`ifndef SYNTHESIS
  a_bad_sig_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && cmd_r.bad_signature) |->
      (cmd_r.run_length == '0 && first_r == '0 && !cmd_r.chunk_done))
    else $error("bad signature result carries a run");

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !cmd_r.bad_signature) |-> (cmd_r.run_length != '0))
    else $error("empty run emitted");

  a_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (load && q_head.chunk_done) |=> (pos_r == '0))
    else $error("cell position not cleared after chunk end");
`endif

endmodule

FILE: rtl/zero_run_height_decoder_core.sv
// Zero-run height decoder top level: configuration registers, front end, queue and back end.
// Depends on zrh_pkg, zrh_if, zrh_front, zrh_fifo, zrh_back.
//
// Takes one chunk byte per cycle on in_ch while the queue is not full and emits height
// runs on out_ch, one result per literal byte, per zero or skip word, and per bad
// signature. The front end parses a byte in the cycle it is accepted; a result reaches
// out_ch through the queue and the output register. A two-entry queue and the output
// register let the input keep flowing while a result waits. Write chunk_columns (offset
// 0x0) and chunk_rows (offset 0x4) only while idle; either write restarts the parse.
module zero_run_height_decoder_core (
  input  logic                       clk,
  input  logic                       rst_n,
  zrh_in_if.sink                     in_ch,
  zrh_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [zrh_pkg::ADDR_W-1:0] paddr,
  input  logic [zrh_pkg::DATA_W-1:0] pwdata,
  output logic [zrh_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  logic [zrh_pkg::DIM_W-1:0] cols_r, cols_nxt;
  logic [zrh_pkg::DIM_W-1:0] rows_r, rows_nxt;
  logic                      cfg_wr;
  logic                      q_push, q_pop, q_full, q_valid;
  zrh_pkg::cmd_t             q_cmd, q_head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    if (cfg_wr) begin
      if (paddr[2] == zrh_pkg::REG_COLS) begin
        cols_nxt = pwdata[zrh_pkg::DIM_W-1:0];
      end else begin
        rows_nxt = pwdata[zrh_pkg::DIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= zrh_pkg::DIM_RESET;
      rows_r <= zrh_pkg::DIM_RESET;
    end else begin
      cols_r <= cols_nxt;
      rows_r <= rows_nxt;
    end
  end

  assign prdata = (paddr[2] == zrh_pkg::REG_ROWS) ?
                  zrh_pkg::DATA_W'(rows_r) : zrh_pkg::DATA_W'(cols_r);

  zrh_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cols    (cols_r),
    .rows    (rows_r),
    .restart (cfg_wr),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_cmd)
  );

  zrh_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  zrh_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (cfg_wr),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: tb/tb_zero_run_height_decoder_core.sv
// Self-checking testbench for zero_run_height_decoder_core: drives chunk byte streams,
// predicts every height run in step with the accepted bytes and checks each result.
// Depends on rtl/zrh_pkg.sv, rtl/zrh_if.sv and the decoder RTL.
`timescale 1ns / 100ps

module tb_zero_run_height_decoder_core;

  localparam int          DRAIN_CYCLES = 8;
  // "chnk", first byte in the low lane
  localparam logic [31:0] CHNK_WORD    = 32'h6B6E6863;

  typedef struct packed {
    logic [7:0]                 height;
    logic [zrh_pkg::RUN_W-1:0]  run_length;
    logic [zrh_pkg::CELL_W-1:0] first_cell;
    logic                       chunk_done;
    logic                       bad_signature;
  } run_rec_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [zrh_pkg::ADDR_W-1:0] paddr;
  logic [zrh_pkg::DATA_W-1:0] pwdata;
  logic [zrh_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  zrh_in_if  in_ch ();
  zrh_out_if out_ch ();

  zero_run_height_decoder_core DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // decoder state mirrored by the run predictor
  logic [zrh_pkg::DIM_W-1:0]  cols_reg;
  logic [zrh_pkg::DIM_W-1:0]  rows_reg;
  logic [zrh_pkg::PH_W-1:0]   parse_ph;
  logic [1:0]                 byte_pos;
  logic [zrh_pkg::WORD_W-1:0] word_acc;
  logic                       sig_ok;
  int unsigned                cells_done;
  logic [zrh_pkg::LEFT_W-1:0] lits_left;

  run_rec_t   pending_runs[$];
  logic [7:0] plan_bytes[$];
  int         in_idle_pct;
  int         out_idle_pct;
  int         err_count;

  function automatic int unsigned eff_dim(input logic [zrh_pkg::DIM_W-1:0] v);
    if (v == '0) begin
      return 1;
    end
    if (v > zrh_pkg::DIM_W'(zrh_pkg::MAX_DIM)) begin
      return zrh_pkg::MAX_DIM;
    end
    return 32'(v);
  endfunction

  function automatic void restart_chunk();
    parse_ph   = zrh_pkg::PH_SIG;
    byte_pos   = 2'd0;
    word_acc   = '0;
    sig_ok     = 1'b1;
    cells_done = 0;
    lits_left  = '0;
  endfunction

  // Cut the run at the chunk's last cell; a full chunk restarts the parse.
  function automatic void push_run(input logic [7:0] h,
                                   input logic [zrh_pkg::WORD_W-1:0] want);
    int unsigned                total;
    int unsigned                remain;
    logic [zrh_pkg::WORD_W-1:0] run;
    run_rec_t                   r;
    total  = eff_dim(cols_reg) * eff_dim(rows_reg);
    remain = total - cells_done;
    run    = (want < remain) ? want : remain;
    r.height        = h;
    r.run_length    = run[zrh_pkg::RUN_W-1:0];
    r.first_cell    = cells_done[zrh_pkg::CELL_W-1:0];
    cells_done      = cells_done + run;
    r.chunk_done    = (cells_done >= total);
    r.bad_signature = 1'b0;
    pending_runs.push_back(r);
    if (r.chunk_done) begin
      restart_chunk();
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    logic [zrh_pkg::WORD_W-1:0] w;
    run_rec_t                   r;
    if (parse_ph == zrh_pkg::PH_LIT) begin
      lits_left = lits_left - zrh_pkg::LEFT_W'(1);
      if (lits_left == '0) begin
        parse_ph = zrh_pkg::PH_COUNT;
      end
      push_run(b, 32'd1);
    end else if (parse_ph == zrh_pkg::PH_SIG) begin
      if (b != CHNK_WORD[8*byte_pos +: 8]) begin
        sig_ok = 1'b0;
      end
      byte_pos = byte_pos + 2'd1;
      if (byte_pos == 2'd0) begin
        if (sig_ok) begin
          parse_ph = zrh_pkg::PH_COUNT;
          word_acc = '0;
        end else begin
          sig_ok = 1'b1;
          r = '0;
          r.bad_signature = 1'b1;
          pending_runs.push_back(r);
        end
      end
    end else begin
      word_acc = word_acc | (zrh_pkg::WORD_W'(b) << (8*byte_pos));
      byte_pos = byte_pos + 2'd1;
      if (byte_pos == 2'd0) begin
        w = word_acc;
        word_acc = '0;
        if (parse_ph == zrh_pkg::PH_COUNT) begin
          if (w == '1) begin
            parse_ph = zrh_pkg::PH_SKIP;
          end else if (w != '0 && !w[31]) begin
            lits_left = w[zrh_pkg::LEFT_W-1:0];
            parse_ph  = zrh_pkg::PH_LIT;
          end else begin
            push_run(8'h00, 32'd1);
          end
        end else begin
          parse_ph = zrh_pkg::PH_COUNT;
          if (w != '0 && !w[31]) begin
            push_run(8'h00, w);
          end else begin
            push_run(8'h00, 32'd1);
          end
        end
      end
    end
  endfunction

  function automatic string fmt_run(input run_rec_t r);
    return $sformatf("h=%0d len=%0d cell=%0d done=%0b bad=%0b", r.height, r.run_length,
                     r.first_cell, r.chunk_done, r.bad_signature);
  endfunction

  // Hold valid across back-to-back requests; drop it only for an idle gap.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid     <= 1'b0;
      in_ch.data_byte <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    decode_byte(b);
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) begin
      send_byte(w[8*i +: 8]);
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [zrh_pkg::DIM_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= zrh_pkg::DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == zrh_pkg::REG_COLS) begin
      cols_reg = v;
    end else begin
      rows_reg = v;
    end
    restart_chunk();
    @(posedge clk);
  endtask

  task automatic cfg_read(input logic idx, input logic [zrh_pkg::DIM_W-1:0] exp_val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== zrh_pkg::DATA_W'(exp_val)) begin
      $display("%0t: register %0d readback, expected %0d, actual %0d", $realtime, idx,
               exp_val, prdata);
      err_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_dims(input logic [zrh_pkg::DIM_W-1:0] cols,
                          input logic [zrh_pkg::DIM_W-1:0] rows);
    wait_idle();
    cfg_write(zrh_pkg::REG_COLS, cols);
    cfg_write(zrh_pkg::REG_ROWS, rows);
    cfg_read(zrh_pkg::REG_COLS, cols);
    cfg_read(zrh_pkg::REG_ROWS, rows);
  endtask

  // Queue the next word, or literal byte, that fits the parse phase, so most streams stay well formed.
  task automatic plan_next();
    logic [31:0] w;
    logic [31:0] rnd;
    int          pick;
    int          k;
    rnd  = $urandom;
    pick = $urandom_range(99);
    if (parse_ph == zrh_pkg::PH_LIT) begin
      plan_bytes.push_back(rnd[7:0]);
      return;
    end
    if (parse_ph == zrh_pkg::PH_SIG) begin
      w = CHNK_WORD;
      if (pick < 10) begin
        k = $urandom_range(3);
        w[8*k +: 8] = rnd[7:0];
      end
    end else if (parse_ph == zrh_pkg::PH_COUNT) begin
      if (pick < 40) begin
        w = $urandom_range(6, 1);
      end else if (pick < 45) begin
        w = {1'b0, rnd[30:0]};
      end else if (pick < 65) begin
        w = '1;
      end else if (pick < 75) begin
        w = '0;
      end else if (pick < 88) begin
        w = {1'b1, rnd[30:0]};
      end else begin
        w = rnd;
      end
    end else begin
      if (pick < 50) begin
        w = $urandom_range(40, 1);
      end else if (pick < 65) begin
        w = {1'b0, rnd[30:0]};
      end else if (pick < 78) begin
        w = '0;
      end else begin
        w = {1'b1, rnd[30:0]};
      end
    end
    for (int i = 0; i < 4; i++) begin
      plan_bytes.push_back(w[8*i +: 8]);
    end
  endtask

  task automatic random_block(input logic [zrh_pkg::DIM_W-1:0] cols,
                              input logic [zrh_pkg::DIM_W-1:0] rows,
                              input int n_bytes);
    logic [7:0] b;
    set_dims(cols, rows);
    repeat (n_bytes) begin
      if (plan_bytes.size() == 0) begin
        plan_next();
      end
      b = plan_bytes.pop_front();
      // occasional stray byte to break the framing
      if ($urandom_range(99) < 3) begin
        b = 8'($urandom);
      end
      send_byte(b);
    end
    plan_bytes.delete();
  endtask

  task automatic test_register_reset();
    cfg_read(zrh_pkg::REG_COLS, zrh_pkg::DIM_RESET);
    cfg_read(zrh_pkg::REG_ROWS, zrh_pkg::DIM_RESET);
  endtask

  // Zero columns count as one: three cells. Surplus literals are dropped at chunk end,
  // then a signature with a wrong last byte.
  task automatic test_chunk_basics();
    set_dims(7'd0, 7'd3);
    send_word(CHNK_WORD);
    send_word(32'd5);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_word(32'h6A6E6863);
  endtask

  // Columns above the limit clamp to 64: zero skip, zero count, then a huge skip cut at
  // the chunk's last cell.
  task automatic test_zero_runs();
    set_dims(7'd127, 7'd1);
    send_word(CHNK_WORD);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'h7FFF_FFFF);
  endtask

  task automatic test_random_stream(input bit full_chunk);
    random_block(7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)), 78);
    random_block(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), 78);
    if (full_chunk) begin
      random_block(7'd64, 7'd64, 78);
    end else begin
      random_block(7'($urandom_range(1, 4)), 7'($urandom_range(1, 16)), 78);
    end
  endtask

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin : check_runs
    run_rec_t want;
    run_rec_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.height        = out_ch.height;
      got.run_length    = out_ch.run_length;
      got.first_cell    = out_ch.first_cell;
      got.chunk_done    = out_ch.chunk_done;
      got.bad_signature = out_ch.bad_signature;
      if (pending_runs.size() == 0) begin
        $display("%0t: unexpected run, expected none, actual %s", $realtime, fmt_run(got));
        err_count++;
      end else begin
        want = pending_runs.pop_front();
        if (got.height !== want.height || got.run_length !== want.run_length ||
            got.first_cell !== want.first_cell || got.chunk_done !== want.chunk_done ||
            got.bad_signature !== want.bad_signature) begin
          $display("%0t: run mismatch, expected %s, actual %s", $realtime, fmt_run(want),
                   fmt_run(got));
          err_count++;
        end
      end
    end
  end

  initial begin
    #10ms;
    $display("tb_zero_run_height_decoder_core: errors");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    out_ch.ready    = 1'b0;
    err_count       = 0;
    in_idle_pct     = 14;
    out_idle_pct    = 80;
    cols_reg        = zrh_pkg::DIM_RESET;
    rows_reg        = zrh_pkg::DIM_RESET;
    restart_chunk();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_reset();
    test_chunk_basics();
    test_zero_runs();
    test_random_stream(1'b0);
    in_idle_pct  = 80;
    out_idle_pct = 14;
    test_random_stream(1'b0);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_stream(1'b1);
    wait_idle();

    if (err_count == 0) begin
      $display("tb_zero_run_height_decoder_core: clean");
    end else begin
      $display("tb_zero_run_height_decoder_core: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/zrh_pkg.sv
rtl/zrh_if.sv
rtl/zrh_front.sv
rtl/zrh_fifo.sv
rtl/zrh_back.sv
rtl/zero_run_height_decoder_core.sv
tb/tb_zero_run_height_decoder_core.sv
